// ===== rtl/rv64sc_pkg.sv =====
// Shared constants and types for the RV64I subset single-cycle core.
// Holds opcode and function codes, data store sizing and operand source codes.
// No dependencies.
package rv64sc_pkg;

    // Data store depth in doublewords; must be a power of two.
    localparam int DATA_WORDS = 128;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);

    // Register file depth and field widths.
    localparam int NUM_REGS    = 32;
    localparam int XLEN        = 64;
    localparam int MEM_INDEX_W = 7;

    // Item actions.
    localparam logic ACT_EXEC    = 1'b0;
    localparam logic ACT_PRELOAD = 1'b1;

    // Major opcodes.
    localparam logic [6:0] OP_REG    = 7'd51;
    localparam logic [6:0] OP_LOAD   = 7'd3;
    localparam logic [6:0] OP_IMM    = 7'd19;
    localparam logic [6:0] OP_BRANCH = 7'd99;
    localparam logic [6:0] OP_STORE  = 7'd35;
    localparam logic [6:0] OP_JALR   = 7'd103;
    localparam logic [6:0] OP_JAL    = 7'd111;

    // Function codes.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_DW   = 3'd3;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [6:0] F7_BASE = 7'd0;

    // Where a registered operand comes from.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_BYP
    } src_sel_t;

    // Picks the value of a registered memory read.
    function automatic logic [XLEN-1:0] pick_src(
        input src_sel_t        sel,
        input logic [XLEN-1:0] mem_data,
        input logic [XLEN-1:0] byp_data
    );
        logic [XLEN-1:0] res;
        case (sel)
            SRC_MEM: res = mem_data;
            SRC_BYP: res = byp_data;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/rv64i_subset_single_cycle_core_top.sv =====
// Top level of the RV64I subset core: decode, execute, register file and data store.
// Depends on rv64sc_pkg for opcodes, sizes and operand source codes.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | request   | in_valid / in_stall    | action, instr_word, preload_index/value
//   out     | result    | out_valid / out_stall  | next_pc, register/memory write, flags
//   cfg     | write     | cfg_we                 | cfg_wdata (last instruction address)
//
// One request per clock is sustained while out_stall is low. A request is decoded and
// executed in the cycle after it is taken, and its result register is loaded at the end
// of that cycle unless a stalled result holds it; a load's data comes from the data
// store's registered read port at the same edge. Register and store writes commit as
// the result is taken; bypass paths cover requests still in flight. Reset clears the
// control state and valid bits, so both stores read as zero at once with no sweep.
// A stalled result holds; in_stall rises only when both stages hold requests.
module rv64i_subset_single_cycle_core_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [31:0]        instr_word,
    input  logic [6:0]         preload_index,
    input  logic signed [63:0] preload_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [63:0]        next_pc,
    output logic               reg_written,
    output logic [4:0]         dest_reg,
    output logic signed [63:0] write_value,
    output logic               mem_written,
    output logic [6:0]         mem_index,
    output logic signed [63:0] store_value,
    output logic               branch_taken,
    output logic               unsupported,
    output logic               done_res
);
    import rv64sc_pkg::*;

    localparam int RA = $clog2(NUM_REGS);

    // Storage.
    logic [XLEN-1:0]       rf_mem [NUM_REGS];
    logic [XLEN-1:0]       dmem [DATA_WORDS];
    logic [NUM_REGS-1:0]   rf_valid_reg;
    logic [DATA_WORDS-1:0] dm_valid_reg;

    // Control state.
    logic             a_valid_reg;
    logic             b_valid_reg;
    logic [XLEN-1:0]  pc_reg;
    logic [31:0]      last_addr_reg;

    // Execute stage registers.
    logic             a_action_reg;
    logic [31:0]      a_instr_reg;
    logic [6:0]       a_pidx_reg;
    logic [XLEN-1:0]  a_pval_reg;
    src_sel_t         rs1_src_reg;
    src_sel_t         rs2_src_reg;
    logic [XLEN-1:0]  rs1_mem_reg;
    logic [XLEN-1:0]  rs2_mem_reg;
    logic [XLEN-1:0]  rs1_byp_reg;
    logic [XLEN-1:0]  rs2_byp_reg;

    // Result stage registers.
    logic [XLEN-1:0]    b_npc_reg;
    logic               b_reg_we_reg;
    logic [RA-1:0]      b_dest_reg;
    logic [XLEN-1:0]    b_wval_reg;
    logic               b_is_load_reg;
    logic               b_store_reg;
    logic               b_dmem_we_reg;
    logic [DMEM_AW-1:0] b_dmem_idx_reg;
    logic [XLEN-1:0]    b_dmem_data_reg;
    logic [6:0]         b_mem_index_reg;
    logic               b_taken_reg;
    logic               b_bad_reg;
    logic               b_done_reg;
    src_sel_t           ld_src_reg;
    logic [XLEN-1:0]    ld_mem_reg;
    logic [XLEN-1:0]    ld_byp_reg;

    // Handshake and stage movement.
    logic b_en;
    logic a_en;
    logic acc_in;
    logic a_move;
    logic b_leave;

    assign b_en     = !b_valid_reg || !out_stall;
    assign a_en     = !a_valid_reg || b_en;
    assign in_stall = !a_en;
    assign acc_in   = in_valid && a_en;
    assign a_move   = a_valid_reg && b_en;
    assign b_leave  = b_valid_reg && !out_stall;

    // Commit of the result stage into the stores.
    logic [XLEN-1:0] ld_data;
    logic [XLEN-1:0] wval_final;
    logic            rf_we;
    logic            dm_we;

    assign ld_data    = pick_src(ld_src_reg, ld_mem_reg, ld_byp_reg);
    assign wval_final = b_is_load_reg ? ld_data : b_wval_reg;
    assign rf_we      = b_leave && b_reg_we_reg;
    assign dm_we      = b_leave && b_dmem_we_reg;

    // Register addresses of the incoming request.
    logic [RA-1:0] in_rs1;
    logic [RA-1:0] in_rs2;

    assign in_rs1 = instr_word[19:15];
    assign in_rs2 = instr_word[24:20];

    // Instruction fields in the execute stage.
    logic [6:0]      op;
    logic [RA-1:0]   rd;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [RA-1:0]   a_rs1;
    logic [RA-1:0]   a_rs2;
    logic [XLEN-1:0] imm_i;
    logic [XLEN-1:0] imm_s;
    logic [XLEN-1:0] imm_b;
    logic [XLEN-1:0] imm_j;

    assign op    = a_instr_reg[6:0];
    assign rd    = a_instr_reg[11:7];
    assign f3    = a_instr_reg[14:12];
    assign a_rs1 = a_instr_reg[19:15];
    assign a_rs2 = a_instr_reg[24:20];
    assign f7    = a_instr_reg[31:25];
    assign imm_i = {{52{a_instr_reg[31]}}, a_instr_reg[31:20]};
    assign imm_s = {{52{a_instr_reg[31]}}, a_instr_reg[31:25], a_instr_reg[11:7]};
    assign imm_b = {{51{a_instr_reg[31]}}, a_instr_reg[31], a_instr_reg[7],
                    a_instr_reg[30:25], a_instr_reg[11:8], 1'b0};
    assign imm_j = {{43{a_instr_reg[31]}}, a_instr_reg[31], a_instr_reg[19:12],
                    a_instr_reg[20], a_instr_reg[30:21], 1'b0};

    // Operands, forwarded from the result stage when it writes the same register.
    logic [XLEN-1:0] op1;
    logic [XLEN-1:0] op2;

    always_comb
    begin
        op1 = pick_src(rs1_src_reg, rs1_mem_reg, rs1_byp_reg);
        op2 = pick_src(rs2_src_reg, rs2_mem_reg, rs2_byp_reg);
        if (b_valid_reg && b_reg_we_reg && b_dest_reg == a_rs1)
        begin
            op1 = wval_final;
        end
        if (b_valid_reg && b_reg_we_reg && b_dest_reg == a_rs2)
        begin
            op2 = wval_final;
        end
    end

    // Arithmetic shared by the decoder.
    logic [XLEN-1:0] sum_i;
    logic [XLEN-1:0] sum_s;
    logic [XLEN-1:0] pc_plus4;

    assign sum_i    = op1 + imm_i;
    assign sum_s    = op1 + imm_s;
    assign pc_plus4 = pc_reg + XLEN'(4);

    // Decode and execute.
    logic               wreg;
    logic [XLEN-1:0]    a_npc;
    logic [XLEN-1:0]    a_wval;
    logic               a_is_load;
    logic               a_store;
    logic               a_dmem_we;
    logic [DMEM_AW-1:0] a_didx;
    logic [XLEN-1:0]    a_ddata;
    logic [6:0]         a_mem_index;
    logic               a_taken;
    logic               a_bad;
    logic               a_reg_we;
    logic               a_done;

    always_comb
    begin
        wreg        = 1'b0;
        a_npc       = pc_plus4;
        a_wval      = '0;
        a_is_load   = 1'b0;
        a_store     = 1'b0;
        a_dmem_we   = 1'b0;
        a_didx      = '0;
        a_ddata     = '0;
        a_mem_index = '0;
        a_taken     = 1'b0;
        a_bad       = 1'b0;
        if (a_action_reg == ACT_PRELOAD)
        begin
            a_npc     = pc_reg;
            a_dmem_we = 1'b1;
            a_didx    = DMEM_AW'(a_pidx_reg);
            a_ddata   = a_pval_reg;
        end
        else
        begin
            unique case (op)
                OP_REG:
                begin
                    if (f7 == F7_BASE && f3 == F3_ADD)
                    begin
                        wreg   = 1'b1;
                        a_wval = op1 + op2;
                    end
                    else if (f7 == F7_BASE && f3 == F3_SLL)
                    begin
                        wreg   = 1'b1;
                        a_wval = op1 << op2[5:0];
                    end
                    else
                    begin
                        a_bad = 1'b1;
                    end
                end
                OP_IMM:
                begin
                    if (f3 == F3_ADD)
                    begin
                        wreg   = 1'b1;
                        a_wval = sum_i;
                    end
                    else if (f3 == F3_SLL && a_instr_reg[31:26] == 6'd0)
                    begin
                        wreg   = 1'b1;
                        a_wval = op1 << a_instr_reg[25:20];
                    end
                    else
                    begin
                        a_bad = 1'b1;
                    end
                end
                OP_LOAD:
                begin
                    if (f3 == F3_DW)
                    begin
                        wreg        = 1'b1;
                        a_is_load   = 1'b1;
                        a_didx      = sum_i[3 +: DMEM_AW];
                        a_mem_index = MEM_INDEX_W'(sum_i[3 +: DMEM_AW]);
                    end
                    else
                    begin
                        a_bad = 1'b1;
                    end
                end
                OP_STORE:
                begin
                    if (f3 == F3_DW)
                    begin
                        a_store     = 1'b1;
                        a_dmem_we   = 1'b1;
                        a_didx      = sum_s[3 +: DMEM_AW];
                        a_ddata     = op2;
                        a_mem_index = MEM_INDEX_W'(sum_s[3 +: DMEM_AW]);
                    end
                    else
                    begin
                        a_bad = 1'b1;
                    end
                end
                OP_BRANCH:
                begin
                    if (f3 == F3_BEQ)
                    begin
                        a_taken = (op1 == op2);
                    end
                    else if (f3 == F3_BNE)
                    begin
                        a_taken = (op1 != op2);
                    end
                    else if (f3 == F3_BGE)
                    begin
                        a_taken = ($signed(op1) >= $signed(op2));
                    end
                    else
                    begin
                        a_bad = 1'b1;
                    end
                    if (a_taken)
                    begin
                        a_npc = pc_reg + imm_b;
                    end
                end
                OP_JAL:
                begin
                    wreg    = 1'b1;
                    a_wval  = pc_plus4;
                    a_taken = 1'b1;
                    a_npc   = pc_reg + imm_j;
                end
                OP_JALR:
                begin
                    if (f3 == F3_JALR)
                    begin
                        wreg    = 1'b1;
                        a_wval  = pc_plus4;
                        a_taken = 1'b1;
                        a_npc   = {sum_i[XLEN-1:1], 1'b0};
                    end
                    else
                    begin
                        a_bad = 1'b1;
                    end
                end
                default:
                begin
                    a_bad = 1'b1;
                end
            endcase
        end
    end

    assign a_reg_we = wreg && (rd != '0);
    assign a_done   = a_npc > {32'd0, last_addr_reg};

    // Control state, valid bits and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            pc_reg        <= '0;
            last_addr_reg <= '0;
            rf_valid_reg  <= '0;
            dm_valid_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                last_addr_reg <= cfg_wdata;
            end
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (a_move)
            begin
                pc_reg <= a_npc;
            end
            if (rf_we)
            begin
                rf_valid_reg[b_dest_reg] <= 1'b1;
            end
            if (dm_we)
            begin
                dm_valid_reg[b_dmem_idx_reg] <= 1'b1;
            end
        end
    end

    // Register file: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[b_dest_reg] <= wval_final;
        end
        if (acc_in)
        begin
            rs1_mem_reg <= rf_mem[in_rs1];
            rs2_mem_reg <= rf_mem[in_rs2];
        end
    end

    // Data store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[b_dmem_idx_reg] <= b_dmem_data_reg;
        end
        if (a_move)
        begin
            ld_mem_reg <= dmem[a_didx];
        end
    end

    // Execute stage capture, with bypass of a register write in the same edge.
    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            a_action_reg <= action;
            a_instr_reg  <= instr_word;
            a_pidx_reg   <= preload_index;
            a_pval_reg   <= preload_value;
            rs1_byp_reg  <= wval_final;
            rs2_byp_reg  <= wval_final;
            if (rf_we && b_dest_reg == in_rs1)
            begin
                rs1_src_reg <= SRC_BYP;
            end
            else if (rf_valid_reg[in_rs1])
            begin
                rs1_src_reg <= SRC_MEM;
            end
            else
            begin
                rs1_src_reg <= SRC_ZERO;
            end
            if (rf_we && b_dest_reg == in_rs2)
            begin
                rs2_src_reg <= SRC_BYP;
            end
            else if (rf_valid_reg[in_rs2])
            begin
                rs2_src_reg <= SRC_MEM;
            end
            else
            begin
                rs2_src_reg <= SRC_ZERO;
            end
        end
    end

    // Result stage capture, with bypass of a store committing in the same edge.
    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_npc_reg       <= a_npc;
            b_reg_we_reg    <= a_reg_we;
            b_dest_reg      <= a_reg_we ? rd : '0;
            b_wval_reg      <= a_wval;
            b_is_load_reg   <= a_is_load;
            b_store_reg     <= a_store;
            b_dmem_we_reg   <= a_dmem_we;
            b_dmem_idx_reg  <= a_didx;
            b_dmem_data_reg <= a_ddata;
            b_mem_index_reg <= a_mem_index;
            b_taken_reg     <= a_taken;
            b_bad_reg       <= a_bad;
            b_done_reg      <= a_done;
            ld_byp_reg      <= b_dmem_data_reg;
            if (dm_we && b_dmem_idx_reg == a_didx)
            begin
                ld_src_reg <= SRC_BYP;
            end
            else if (dm_valid_reg[a_didx])
            begin
                ld_src_reg <= SRC_MEM;
            end
            else
            begin
                ld_src_reg <= SRC_ZERO;
            end
        end
    end

    // Result outputs.
    assign out_valid    = b_valid_reg;
    assign next_pc      = b_npc_reg;
    assign reg_written  = b_reg_we_reg;
    assign dest_reg     = b_dest_reg;
    assign write_value  = b_reg_we_reg ? wval_final : '0;
    assign mem_written  = b_store_reg;
    assign mem_index    = b_mem_index_reg;
    assign store_value  = b_store_reg ? b_dmem_data_reg : '0;
    assign branch_taken = b_taken_reg;
    assign unsupported  = b_bad_reg;
    assign done_res     = b_done_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the RV64I subset single-cycle core.
// It depends on rv64sc_pkg and rv64i_subset_single_cycle_core_top.
module tb;
    import rv64sc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 213;
    localparam int NUM_PHASES = 6;
    localparam int MAX_REPORTS = 40;

    // One retired request as seen on the result port, in port order.
    typedef struct packed {
        logic [63:0] npc;
        logic        reg_wr;
        logic [4:0]  rd;
        logic [63:0] wval;
        logic        mem_wr;
        logic [6:0]  midx;
        logic [63:0] sval;
        logic        taken;
        logic        bad;
        logic        done;
    } core_result_t;

    // Architectural shadow of the core plus the queue of results still owed.
    class core_scoreboard;
        logic [63:0]  pc;
        logic [63:0]  regs[NUM_REGS];
        logic [63:0]  dmem[DATA_WORDS];
        logic [31:0]  last_addr;
        core_result_t owed_results[$];
        int           errors;

        function new();
            pc = '0;
            last_addr = '0;
            errors = 0;
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
        endfunction

        function void set_last_addr(logic [31:0] value);
            last_addr = value;
        endfunction

        // Executes one accepted request on the shadow state and queues its result.
        function void note_request(logic act, logic [31:0] w, logic [6:0] pidx,
                                   logic [63:0] pval);
            core_result_t r;
            logic [63:0]  a, b, imm_i, imm_s, imm_b, imm_j, npc, val;
            logic         wr;
            int           idx;
            r = '0;
            if (act == ACT_PRELOAD) begin
                dmem[pidx % DATA_WORDS] = pval;
                r.npc = pc;
                r.done = pc > {32'd0, last_addr};
            end else begin
                a = regs[w[19:15]];
                b = regs[w[24:20]];
                imm_i = {{52{w[31]}}, w[31:20]};
                imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
                imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                npc = pc + 64'd4;
                wr = 1'b0;
                val = '0;
                case (w[6:0])
                    OP_REG: begin
                        if (w[31:25] == F7_BASE && w[14:12] == F3_ADD) begin
                            wr = 1'b1;
                            val = a + b;
                        end else if (w[31:25] == F7_BASE && w[14:12] == F3_SLL) begin
                            wr = 1'b1;
                            val = a << b[5:0];
                        end else begin
                            r.bad = 1'b1;
                        end
                    end
                    OP_IMM: begin
                        if (w[14:12] == F3_ADD) begin
                            wr = 1'b1;
                            val = a + imm_i;
                        end else if (w[14:12] == F3_SLL && w[31:26] == 6'd0) begin
                            wr = 1'b1;
                            val = a << w[25:20];
                        end else begin
                            r.bad = 1'b1;
                        end
                    end
                    OP_LOAD: begin
                        if (w[14:12] == F3_DW) begin
                            idx = int'(((a + imm_i) >> 3) % DATA_WORDS);
                            r.midx = 7'(idx);
                            wr = 1'b1;
                            val = dmem[idx];
                        end else begin
                            r.bad = 1'b1;
                        end
                    end
                    OP_STORE: begin
                        if (w[14:12] == F3_DW) begin
                            idx = int'(((a + imm_s) >> 3) % DATA_WORDS);
                            r.midx = 7'(idx);
                            r.mem_wr = 1'b1;
                            r.sval = b;
                            dmem[idx] = b;
                        end else begin
                            r.bad = 1'b1;
                        end
                    end
                    OP_BRANCH: begin
                        case (w[14:12])
                            F3_BEQ:  r.taken = (a == b);
                            F3_BNE:  r.taken = (a != b);
                            F3_BGE:  r.taken = ($signed(a) >= $signed(b));
                            default: r.bad = 1'b1;
                        endcase
                        if (r.taken) npc = pc + imm_b;
                    end
                    OP_JAL: begin
                        wr = 1'b1;
                        val = pc + 64'd4;
                        r.taken = 1'b1;
                        npc = pc + imm_j;
                    end
                    OP_JALR: begin
                        if (w[14:12] == F3_JALR) begin
                            wr = 1'b1;
                            val = pc + 64'd4;
                            r.taken = 1'b1;
                            npc = (a + imm_i) & ~64'd1;
                        end else begin
                            r.bad = 1'b1;
                        end
                    end
                    default: r.bad = 1'b1;
                endcase
                // Writes to x0 vanish and leave the write fields at zero.
                if (wr && w[11:7] != 5'd0) begin
                    regs[w[11:7]] = val;
                    r.reg_wr = 1'b1;
                    r.rd = w[11:7];
                    r.wval = val;
                end
                pc = npc;
                r.npc = npc;
                r.done = npc > {32'd0, last_addr};
            end
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        endfunction

        // Matches one result taken from the core against the oldest one owed.
        function void check_result(core_result_t got);
            core_result_t want;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual next_pc %h",
                             $time, got.npc);
            end else begin
                want = owed_results.pop_front();
                compare_field("next_pc", want.npc, got.npc);
                compare_field("reg_written", 64'(want.reg_wr), 64'(got.reg_wr));
                compare_field("dest_reg", 64'(want.rd), 64'(got.rd));
                compare_field("write_value", want.wval, got.wval);
                compare_field("mem_written", 64'(want.mem_wr), 64'(got.mem_wr));
                compare_field("mem_index", 64'(want.midx), 64'(got.midx));
                compare_field("store_value", want.sval, got.sval);
                compare_field("branch_taken", 64'(want.taken), 64'(got.taken));
                compare_field("unsupported", 64'(want.bad), 64'(got.bad));
                compare_field("done_res", 64'(want.done), 64'(got.done));
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [31:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [31:0]        instr_word;
    logic [6:0]         preload_index;
    logic signed [63:0] preload_value;
    logic               out_valid;
    logic               out_stall;
    logic [63:0]        next_pc;
    logic               reg_written;
    logic [4:0]         dest_reg;
    logic signed [63:0] write_value;
    logic               mem_written;
    logic [6:0]         mem_index;
    logic signed [63:0] store_value;
    logic               branch_taken;
    logic               unsupported;
    logic               done_res;

    core_scoreboard sb;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             cycle_count = 0;

    rv64i_subset_single_cycle_core_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .instr_word    (instr_word),
        .preload_index (preload_index),
        .preload_value (preload_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_pc       (next_pc),
        .reg_written   (reg_written),
        .dest_reg      (dest_reg),
        .write_value   (write_value),
        .mem_written   (mem_written),
        .mem_index     (mem_index),
        .store_value   (store_value),
        .branch_taken  (branch_taken),
        .unsupported   (unsupported),
        .done_res      (done_res)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: check every taken result, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(core_result_t'({next_pc, reg_written, dest_reg, write_value,
                                            mem_written, mem_index, store_value,
                                            branch_taken, unsupported, done_res}));
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Instruction encoders.
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, F3_DW, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // Registers are drawn mostly from a small set so that operands collide often.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 9) < 7)
            return 5'($urandom_range(0, 7));
        return 5'($urandom);
    endfunction

    function automatic logic [11:0] pick_imm();
        if ($urandom_range(0, 1) == 0)
            return 12'($signed($urandom_range(0, 31)) - 16);
        return 12'($urandom);
    endfunction

    // Offers one request, with random idle cycles ahead of it, until it is taken.
    task automatic send_request(logic act, logic [31:0] w, logic [6:0] idx, logic [63:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        instr_word <= w;
        preload_index <= idx;
        preload_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(act, w, idx, val);
    endtask

    task automatic send_exec(logic [31:0] w);
        send_request(ACT_EXEC, w, 7'($urandom), {$urandom, $urandom});
    endtask

    task automatic send_preload(logic [6:0] idx, logic [63:0] val);
        send_request(ACT_PRELOAD, $urandom, idx, val);
    endtask

    // One random request: mostly well-formed instructions, some preloads and noise.
    task automatic send_random();
        logic [6:0]  opcodes[7];
        int unsigned pick;
        logic [31:0] w;
        logic [4:0]  rd, rs1, rs2;
        logic [11:0] imm;
        opcodes = '{OP_REG, OP_LOAD, OP_IMM, OP_BRANCH, OP_STORE, OP_JALR, OP_JAL};
        pick = $urandom_range(0, 99);
        rd = pick_reg();
        rs1 = pick_reg();
        rs2 = pick_reg();
        imm = pick_imm();
        if (pick < 8) begin
            if ($urandom_range(0, 2) == 0)
                send_preload(7'($urandom), 64'($urandom_range(0, 15)));
            else
                send_preload(7'($urandom), {$urandom, $urandom});
        end else begin
            if (pick < 14) begin
                w = $urandom;
            end else if (pick < 20) begin
                // Known opcode with arbitrary function fields.
                w = $urandom;
                w[6:0] = opcodes[$urandom_range(0, 6)];
            end else begin
                case ($urandom_range(0, 10))
                    0: w = enc_r(F7_BASE, rs2, rs1, F3_ADD, rd);
                    1: w = enc_r(F7_BASE, rs2, rs1, F3_SLL, rd);
                    2: w = enc_i(imm, rs1, F3_ADD, rd, OP_IMM);
                    3: w = enc_i({6'd0, 6'($urandom)}, rs1, F3_SLL, rd, OP_IMM);
                    4: w = enc_i(imm, rs1, F3_DW, rd, OP_LOAD);
                    5: w = enc_s(imm, rs2, rs1);
                    6: w = enc_b({12'($urandom), 1'b0}, rs2, rs1, F3_BEQ);
                    7: w = enc_b({12'($urandom), 1'b0}, rs2, rs1, F3_BNE);
                    8: w = enc_b({12'($urandom), 1'b0}, rs2, rs1, F3_BGE);
                    9: w = enc_j({20'($urandom), 1'b0}, rd);
                    default: w = enc_i(12'($urandom), rs1, F3_JALR, rd, OP_JALR);
                endcase
            end
            send_exec(w);
        end
    endtask

    task automatic write_last_addr(logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_last_addr(value);
        cfg_we <= 1'b0;
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge clk);
    endtask

    // Main sequence: reset, directed requests, then random phases.
    initial
    begin
        int          send_pcts[NUM_PHASES];
        int          stall_pcts[NUM_PHASES];
        logic [31:0] last_addrs[NUM_PHASES];
        send_pcts = '{0, 73, 0, 28, 0, 28};
        stall_pcts = '{0, 0, 73, 28, 0, 28};
        last_addrs = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h0000_1000, 32'h8000_0000,
                       32'($urandom_range(0, 4095))};
        sb = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        action <= ACT_EXEC;
        instr_word <= '0;
        preload_index <= '0;
        preload_value <= '0;
        out_stall <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_last_addr(32'h0000_0100);

        // Directed: field extremes, every instruction and the corner cases.
        send_preload(7'd0, 64'h8000_0000_0000_0000);
        send_preload(7'd127, 64'h7FFF_FFFF_FFFF_FFFF);
        send_exec(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd1, OP_IMM));
        send_exec(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2, OP_IMM));
        send_exec(enc_i(12'h800, 5'd0, F3_ADD, 5'd3, OP_IMM));
        send_exec(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd4));
        // Register shift amount comes from the low six bits only.
        send_exec(enc_r(F7_BASE, 5'd1, 5'd2, F3_SLL, 5'd5));
        send_exec(enc_i(12'h03F, 5'd2, F3_SLL, 5'd6, OP_IMM));
        // Immediate shift with upper immediate bits set is not implemented.
        send_exec(enc_i(12'h43F, 5'd2, F3_SLL, 5'd6, OP_IMM));
        // Negative address wraps to the top doubleword.
        send_exec(enc_i(12'hFF8, 5'd0, F3_DW, 5'd7, OP_LOAD));
        send_exec(enc_i(12'h000, 5'd0, F3_DW, 5'd8, OP_LOAD));
        // Misaligned address beyond the store depth: low bits dropped, index wraps.
        send_exec(enc_s(12'h7FF, 5'd4, 5'd0));
        send_exec(enc_i(12'h7F8, 5'd0, F3_DW, 5'd9, OP_LOAD));
        // Write to x0 is discarded.
        send_exec(enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd0));
        send_exec(enc_b(13'h1000, 5'd1, 5'd1, F3_BEQ));
        send_exec(enc_b(13'h0008, 5'd1, 5'd1, F3_BNE));
        send_exec(enc_b(13'h0FFE, 5'd1, 5'd3, F3_BGE));
        send_exec(enc_b(13'h0010, 5'd3, 5'd1, F3_BGE));
        send_exec(enc_b(13'h000C, 5'd2, 5'd1, F3_BNE));
        send_exec(enc_j(21'h1FFFFE, 5'd10));
        send_exec(enc_j(21'h0FFFFE, 5'd0));
        // Jump through register clears bit zero of the target.
        send_exec(enc_i(12'h000, 5'd1, F3_JALR, 5'd11, OP_JALR));
        send_exec(enc_i(12'h000, 5'd1, 3'd1, 5'd12, OP_JALR));
        send_exec(enc_r(7'h20, 5'd2, 5'd1, F3_ADD, 5'd13));
        send_exec(32'hFFFF_FFFF);
        send_exec(enc_b(13'h0008, 5'd1, 5'd1, 3'd2));
        send_exec(enc_i(12'h000, 5'd0, 3'd2, 5'd14, OP_LOAD));
        send_exec(32'h0000_0000);

        // Random phases, each with its own idle pattern and done threshold.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            send_idle_pct = send_pcts[ph];
            stall_pct = stall_pcts[ph];
            write_last_addr(last_addrs[ph]);
            repeat (ITEMS_PER_PHASE) send_random();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.owed_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
